/* rtl/esc_tfd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ESC telemetry frame decoder package
// Shared constants, result types and the CRC-8 byte update function.
// ----------------------------------------------------------------------------
package esc_tfd_pkg;

    localparam int unsigned FRAME_BYTES = 10;
    localparam int unsigned POS_W       = 4;

    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_TOP  = 8'h80;

    // Frame byte positions that carry a field.
    localparam logic [POS_W-1:0] POS_TEMP     = 4'd0;
    localparam logic [POS_W-1:0] POS_VOLT_HI  = 4'd1;
    localparam logic [POS_W-1:0] POS_VOLT_LO  = 4'd2;
    localparam logic [POS_W-1:0] POS_CURR_HI  = 4'd3;
    localparam logic [POS_W-1:0] POS_CURR_LO  = 4'd4;
    localparam logic [POS_W-1:0] POS_SPEED_HI = 4'd7;
    localparam logic [POS_W-1:0] POS_SPEED_LO = 4'd8;
    localparam logic [POS_W-1:0] POS_CRC      = POS_W'(FRAME_BYTES - 1);

    // Input action codes.
    localparam logic ACT_BYTE    = 1'b0;
    localparam logic ACT_TIMEOUT = 1'b1;

    typedef struct packed {
        logic [7:0]  temperature;
        logic [15:0] voltage;
        logic [15:0] current;
        logic [15:0] speed;
        logic        crc_ok;
    } frame_result_t;

    typedef struct packed {
        logic             frame_done;
        logic [POS_W-1:0] position;
    } asm_status_t;

    // MSB-first CRC-8 update of one byte, no reflection.
    function automatic logic [7:0] crc8_feed(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] r;
        r = acc ^ data;
        for (int k = 0; k < 8; k++) begin
            if ((r & CRC_TOP) != 8'h00)
            begin
                r = (r << 1) ^ CRC_POLY;
            end
            else
            begin
                r = r << 1;
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/esc_telemetry_frame_decoder_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ESC telemetry frame decoder, top level
// Assembles 10-byte motor-controller telemetry frames and checks their CRC-8.
// ----------------------------------------------------------------------------
// Path: the tenth byte is held in the input register; its frame result then
// goes to the result register and out_valid. One transaction is taken per cycle
// unless that last byte waits on a full result register; the frame state update
// is a single pass of logic between the input register and the result register.
// Reset: rst_n clears the byte position, the running CRC, the field holds and
// both valid flags, so the first byte after reset starts a new frame.
// ----------------------------------------------------------------------------
module esc_telemetry_frame_decoder_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input channel: received byte or idle timeout.
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        action,
    input  wire logic [7:0]  rx_byte,
    // Output channel: one transaction per completed frame.
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       temperature,
    output logic [15:0]      voltage,
    output logic [15:0]      current,
    output logic [15:0]      speed,
    output logic             crc_ok
);

    // Input register. It holds one accepted transaction until the frame
    // logic can consume it.
    logic       in_valid_reg, in_valid_next;
    logic       action_reg;
    logic [7:0] byte_reg;

    // Result register. It parts the frame logic from the downstream side so
    // that bytes that do not complete a frame keep flowing while a result waits.
    logic                       out_valid_reg, out_valid_next;
    esc_tfd_pkg::frame_result_t result_reg;

    esc_tfd_pkg::asm_status_t   asm_status;
    esc_tfd_pkg::frame_result_t asm_result;

    logic produces;
    logic advance;
    logic out_free;

    // The result slot is free when empty or emptied at this edge.
    assign out_free = !out_valid_reg || out_ready;

    // A buffered transaction moves on unless it would complete a frame while
    // the result slot is still occupied.
    assign produces = in_valid_reg && asm_status.frame_done;
    assign advance  = in_valid_reg && (!asm_status.frame_done || out_free);

    // New input is taken whenever the input register empties at this edge.
    assign in_ready = !in_valid_reg || advance;

    esc_tfd_assembler u_assembler (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .action  (action_reg),
        .rx_byte (byte_reg),
        .status  (asm_status),
        .result  (asm_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && produces)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            action_reg <= action;
            byte_reg   <= rx_byte;
        end
        if (advance && produces)
        begin
            result_reg <= asm_result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign temperature = result_reg.temperature;
    assign voltage     = result_reg.voltage;
    assign current     = result_reg.current;
    assign speed       = result_reg.speed;
    assign crc_ok      = result_reg.crc_ok;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // The frame position never leaves the range of a frame.
    a_position_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        asm_status.position < esc_tfd_pkg::POS_W'(esc_tfd_pkg::FRAME_BYTES)
    ) else $error("frame position out of range");

    // A new frame result never overwrites one that has not been taken.
    a_no_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        (advance && produces) |-> (!out_valid_reg || out_ready)
    ) else $error("frame result overwritten");

    // A stalled buffered transaction keeps its byte for the next cycle.
    a_input_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(byte_reg))
    ) else $error("buffered input lost while stalled");

    // A result appears only after the last byte of a frame was consumed.
    a_result_source: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && produces)
    ) else $error("result without a completed frame");

endmodule
`default_nettype wire

/* rtl/esc_tfd_assembler.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ESC telemetry frame assembler
// Tracks the byte position, running CRC and field holds of the current frame.
// ----------------------------------------------------------------------------
module esc_tfd_assembler (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      step,
    input  wire logic                      action,
    input  wire logic [7:0]                rx_byte,
    output esc_tfd_pkg::asm_status_t       status,
    output esc_tfd_pkg::frame_result_t     result
);

    logic [esc_tfd_pkg::POS_W-1:0] pos_reg, pos_next, pos_eff;
    logic [7:0]  crc_reg, crc_next, crc_base;
    logic [7:0]  temp_reg, temp_next;
    logic [15:0] volt_reg, volt_next;
    logic [15:0] curr_reg, curr_next;
    logic [15:0] speed_reg, speed_next;
    logic        last_byte;

    // An out-of-range position is treated as the start of a new frame.
    assign pos_eff   = (pos_reg >= esc_tfd_pkg::POS_W'(esc_tfd_pkg::FRAME_BYTES))
                       ? esc_tfd_pkg::POS_TEMP : pos_reg;
    assign last_byte = (action == esc_tfd_pkg::ACT_BYTE) && (pos_eff == esc_tfd_pkg::POS_CRC);
    assign crc_base  = (pos_eff == esc_tfd_pkg::POS_TEMP) ? 8'h00 : crc_reg;

    always_comb
    begin
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        temp_next  = temp_reg;
        volt_next  = volt_reg;
        curr_next  = curr_reg;
        speed_next = speed_reg;
        if (action == esc_tfd_pkg::ACT_TIMEOUT)
        begin
            pos_next = esc_tfd_pkg::POS_TEMP;
            crc_next = 8'h00;
        end
        else
        begin
            case (pos_eff)
                esc_tfd_pkg::POS_TEMP:     temp_next         = rx_byte;
                esc_tfd_pkg::POS_VOLT_HI:  volt_next[15:8]   = rx_byte;
                esc_tfd_pkg::POS_VOLT_LO:  volt_next[7:0]    = rx_byte;
                esc_tfd_pkg::POS_CURR_HI:  curr_next[15:8]   = rx_byte;
                esc_tfd_pkg::POS_CURR_LO:  curr_next[7:0]    = rx_byte;
                esc_tfd_pkg::POS_SPEED_HI: speed_next[15:8]  = rx_byte;
                esc_tfd_pkg::POS_SPEED_LO: speed_next[7:0]   = rx_byte;
                default: ;
            endcase
            if (last_byte)
            begin
                pos_next = esc_tfd_pkg::POS_TEMP;
                crc_next = 8'h00;
            end
            else
            begin
                pos_next = pos_eff + 1'b1;
                crc_next = esc_tfd_pkg::crc8_feed(crc_base, rx_byte);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            crc_reg   <= '0;
            temp_reg  <= '0;
            volt_reg  <= '0;
            curr_reg  <= '0;
            speed_reg <= '0;
        end
        else if (step)
        begin
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            temp_reg  <= temp_next;
            volt_reg  <= volt_next;
            curr_reg  <= curr_next;
            speed_reg <= speed_next;
        end
    end

    // Byte 9 writes no field, so the holds already carry the whole frame.
    assign result.temperature = temp_reg;
    assign result.voltage     = volt_reg;
    assign result.current     = curr_reg;
    assign result.speed       = speed_reg;
    assign result.crc_ok      = (rx_byte == crc_reg);

    assign status.frame_done  = last_byte;
    assign status.position    = pos_reg;

endmodule
`default_nettype wire

/* dv/esc_telemetry_frame_decoder_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ESC telemetry frame decoder testbench
// Sends byte and timeout transactions, predicts every decoded frame and
// checks each result transaction field by field under random flow control.
// ----------------------------------------------------------------------------
module esc_telemetry_frame_decoder_unit_test;

    // Run length and flow-control constants.
    localparam int unsigned CLK_HALF      = 10;
    localparam int unsigned RESET_CYCLES  = 6;
    localparam int unsigned PHASE_ITEMS   = 430;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned PRESS_FRAMES  = 8;
    localparam int unsigned TAIL_CYCLES   = 8;
    localparam int unsigned CYCLE_LIMIT   = 200000;

    // ------------------------------------------------------------------------
    // Frame scoreboard. It keeps its own copy of the frame assembly state,
    // turns each accepted input transaction into the frame it completes (if
    // any), and compares result transactions against the oldest such frame.
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        logic [esc_tfd_pkg::POS_W-1:0] position;
        logic [7:0]                    crc_acc;
        logic [7:0]                    temp_q;
        logic [15:0]                   volt_q;
        logic [15:0]                   curr_q;
        logic [15:0]                   speed_q;
        esc_tfd_pkg::frame_result_t    pending_frames[$];
        int unsigned                   mismatches;

        function new();
            position   = '0;
            crc_acc    = '0;
            temp_q     = '0;
            volt_q     = '0;
            curr_q     = '0;
            speed_q    = '0;
            mismatches = 0;
        endfunction

        // CRC-8, polynomial 0x07, processed one data bit at a time, MSB first.
        static function logic [7:0] crc8_next(logic [7:0] acc, logic [7:0] data);
            logic [7:0] r;
            logic       fb;
            r = acc;
            for (int i = 7; i >= 0; i--)
            begin
                fb = r[7] ^ data[i];
                r  = {r[6:0], 1'b0} ^ (fb ? esc_tfd_pkg::CRC_POLY : 8'h00);
            end
            return r;
        endfunction

        function void note_input(logic act, logic [7:0] b);
            logic [esc_tfd_pkg::POS_W-1:0] pos;
            esc_tfd_pkg::frame_result_t    done;
            // A timeout only resynchronizes; the field holds keep their values.
            if (act == esc_tfd_pkg::ACT_TIMEOUT)
            begin
                position = '0;
                crc_acc  = '0;
                return;
            end
            pos = position;
            if (pos >= esc_tfd_pkg::FRAME_BYTES)
            begin
                pos = '0;
            end
            if (pos == esc_tfd_pkg::POS_TEMP)
            begin
                crc_acc = '0;
            end
            case (pos)
                esc_tfd_pkg::POS_TEMP:     temp_q         = b;
                esc_tfd_pkg::POS_VOLT_HI:  volt_q[15:8]   = b;
                esc_tfd_pkg::POS_VOLT_LO:  volt_q[7:0]    = b;
                esc_tfd_pkg::POS_CURR_HI:  curr_q[15:8]   = b;
                esc_tfd_pkg::POS_CURR_LO:  curr_q[7:0]    = b;
                esc_tfd_pkg::POS_SPEED_HI: speed_q[15:8]  = b;
                esc_tfd_pkg::POS_SPEED_LO: speed_q[7:0]   = b;
                default: ;
            endcase
            if (pos != esc_tfd_pkg::POS_CRC)
            begin
                crc_acc  = crc8_next(crc_acc, b);
                position = pos + 1'b1;
            end
            else
            begin
                // The last byte carries the checksum; the frame is reported
                // whether it matches or not.
                done.temperature = temp_q;
                done.voltage     = volt_q;
                done.current     = curr_q;
                done.speed       = speed_q;
                done.crc_ok      = (b == crc_acc);
                pending_frames.push_back(done);
                position = '0;
                crc_acc  = '0;
            end
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        task check_result(esc_tfd_pkg::frame_result_t seen);
            esc_tfd_pkg::frame_result_t want;
            if (pending_frames.size() == 0)
            begin
                report_mismatch($sformatf("frame with no prediction waiting: %h", seen));
                return;
            end
            want = pending_frames.pop_front();
            if (seen.temperature !== want.temperature)
                report_mismatch($sformatf("temperature %h, predicted %h",
                                          seen.temperature, want.temperature));
            if (seen.voltage !== want.voltage)
                report_mismatch($sformatf("voltage %h, predicted %h",
                                          seen.voltage, want.voltage));
            if (seen.current !== want.current)
                report_mismatch($sformatf("current %h, predicted %h",
                                          seen.current, want.current));
            if (seen.speed !== want.speed)
                report_mismatch($sformatf("speed %h, predicted %h",
                                          seen.speed, want.speed));
            if (seen.crc_ok !== want.crc_ok)
                report_mismatch($sformatf("crc_ok %b, predicted %b",
                                          seen.crc_ok, want.crc_ok));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals. Every block input has a known value from time zero.
    // ------------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic        action    = esc_tfd_pkg::ACT_BYTE;
    logic [7:0]  rx_byte   = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  temperature;
    logic [15:0] voltage;
    logic [15:0] current;
    logic [15:0] speed;
    logic        crc_ok;

    // Flow-control knobs, in percent of cycles.
    int unsigned send_idle_pct = 0;
    int unsigned rx_stall_pct  = 0;
    // While set, the receiver refuses every result transaction.
    logic        rx_hold       = 1'b0;

    int unsigned items_sent  = 0;
    int unsigned cycle_count = 0;

    frame_scoreboard sb = new();

    esc_telemetry_frame_decoder_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .temperature (temperature),
        .voltage     (voltage),
        .current     (current),
        .speed       (speed),
        .crc_ok      (crc_ok)
    );

    // 20 ns clock period.
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Watchdog. A hung handshake ends the run here instead of running forever.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver. Ready is redrawn every cycle from the stall percentage unless
    // a long hold-off is in progress, in which case it stays low throughout.
    always @(posedge clk)
    begin
        if (rx_hold)
        begin
            out_ready <= 1'b0;
        end
        else if (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Monitor. Both channels are sampled at the rising edge, which sees the
    // values that were stable before the edge. A result can never stem from
    // an input accepted at the same edge, so checking first is safe.
    always @(posedge clk)
    begin : monitor
        esc_tfd_pkg::frame_result_t seen;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                seen = {temperature, voltage, current, speed, crc_ok};
                sb.check_result(seen);
            end
            if (in_valid && in_ready)
            begin
                sb.note_input(action, rx_byte);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks.
    // ------------------------------------------------------------------------

    // Offers one transaction and returns at the edge that accepts it. Valid
    // stays high on return, so the caller either offers the next item right
    // away or lowers valid before letting time pass.
    task automatic send_item(input logic act, input logic [7:0] b);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    // Field bytes lean toward the extremes so the full-scale values show up.
    function automatic logic [7:0] field_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // A complete frame with random content. A bad checksum is made by
    // flipping at least one bit of the correct one.
    task automatic send_frame(input bit good_crc);
        logic [7:0] b;
        logic [7:0] crc;
        crc = 8'h00;
        for (int i = 0; i < esc_tfd_pkg::FRAME_BYTES - 1; i++)
        begin
            b   = field_byte();
            crc = frame_scoreboard::crc8_next(crc, b);
            send_item(esc_tfd_pkg::ACT_BYTE, b);
        end
        if (!good_crc)
        begin
            crc = crc ^ 8'($urandom_range(1, 255));
        end
        send_item(esc_tfd_pkg::ACT_BYTE, crc);
    endtask

    // Timeout transaction; the byte lane carries junk that must be ignored.
    task automatic send_timeout();
        send_item(esc_tfd_pkg::ACT_TIMEOUT, 8'($urandom_range(255)));
    endtask

    // Mostly well-formed frames, with truncated frames, lone timeouts and
    // runs of misaligned noise mixed in. Noise is always followed by a
    // timeout so that later frames line up again.
    task automatic random_traffic(input int unsigned target);
        int unsigned pick;
        int unsigned n;
        while (items_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                send_frame($urandom_range(99) < 85);
            end
            else if (pick < 80)
            begin
                n = $urandom_range(1, esc_tfd_pkg::FRAME_BYTES - 1);
                repeat (n) send_item(esc_tfd_pkg::ACT_BYTE, field_byte());
                send_timeout();
            end
            else if (pick < 88)
            begin
                send_timeout();
            end
            else
            begin
                n = $urandom_range(1, 15);
                repeat (n) send_item(esc_tfd_pkg::ACT_BYTE, 8'($urandom_range(255)));
                send_timeout();
            end
        end
    endtask

    // Stops offering and waits until every predicted frame has arrived. The
    // first edge lets the monitor record the last accepted transaction
    // before the queue is looked at.
    task automatic drain_frames();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_frames.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic set_flow(input int unsigned idle_pct, input int unsigned stall_pct);
        send_idle_pct = idle_pct;
        rx_stall_pct  = stall_pct;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        // Reset is asserted from time zero and released once, synchronously
        // to the clock.
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, no flow-control gaps.
        set_flow(0, 0);
        // A timeout right after reset, when the frame is already at its start.
        send_timeout();
        // All-zero frame: the checksum of nine zero bytes is zero, so it passes.
        repeat (esc_tfd_pkg::FRAME_BYTES) send_item(esc_tfd_pkg::ACT_BYTE, 8'h00);
        // A partial frame of all-ones cut short by a timeout whose byte lane
        // also holds all ones.
        repeat (3) send_item(esc_tfd_pkg::ACT_BYTE, 8'hFF);
        send_item(esc_tfd_pkg::ACT_TIMEOUT, 8'hFF);
        // All-ones frame, maximum fields, with all ones in the checksum byte.
        repeat (esc_tfd_pkg::FRAME_BYTES) send_item(esc_tfd_pkg::ACT_BYTE, 8'hFF);
        drain_frames();

        // Random part over four flow-control phases.
        set_flow(0, 0);
        random_traffic(items_sent + PHASE_ITEMS);
        drain_frames();

        set_flow(49, 0);
        random_traffic(items_sent + PHASE_ITEMS);
        drain_frames();

        set_flow(0, 49);
        random_traffic(items_sent + PHASE_ITEMS);
        drain_frames();

        set_flow(9, 9);
        random_traffic(items_sent + PHASE_ITEMS);
        drain_frames();

        // Back-pressure: the receiver refuses results for a long stretch while
        // the sender keeps offering full frames, so the result register fills
        // and the input channel has to stall. Afterwards the sender pauses
        // until every predicted frame has come out.
        set_flow(0, 0);
        rx_hold <= 1'b1;
        fork
            begin
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
            begin
                repeat (PRESS_FRAMES) send_frame($urandom_range(99) < 85);
            end
        join
        drain_frames();

        if (sb.pending_frames.size() != 0)
        begin
            sb.report_mismatch($sformatf("%0d predicted frames never arrived",
                                         sb.pending_frames.size()));
        end
        if (sb.mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
